// ===== design/ttlog_pkg.sv =====
package ttlog_pkg;

   localparam int LOG_DEPTH_DEFAULT = 16;
   localparam int TICKS_DEFAULT     = 1000000;

   localparam int TYPE_W      = 8;
   localparam int CODE_W      = 8;
   localparam int TIME_W      = 64;
   localparam int MAXE_W      = 5;
   localparam int SECS_W      = 16;
   localparam int DIV_CNT_W   = 2;
   localparam int RESULT_CAP  = 16;
   localparam int CFG_W       = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 88;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 2;
   localparam int EVENT_W     = 32;

   localparam logic [SECS_W-1:0]     SECS_MAX   = {SECS_W{1'b1}};
   localparam logic [MAXE_W-1:0]     DUMP_CAP   = MAXE_W'(RESULT_CAP);
   localparam logic [CSR_IDX_W-1:0]  REG_TYPE_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0]  REG_RESULT_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0]  REG_ERROR_CODE   = 2'd2;

   // Steps of the seconds divide, counted down.
   localparam logic [DIV_CNT_W-1:0]  DIV_EST = 2'd2;
   localparam logic [DIV_CNT_W-1:0]  DIV_MUL = 2'd1;
   localparam logic [DIV_CNT_W-1:0]  DIV_FIX = 2'd0;

   localparam logic [CFG_W-1:0] TYPE_LIMIT_RESET   = 8'd31;
   localparam logic [CFG_W-1:0] RESULT_LIMIT_RESET = 8'd7;
   localparam logic [CFG_W-1:0] ERROR_CODE_RESET   = 8'd2;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_END   = 2'd1,
      OP_DUMP  = 2'd2,
      OP_CLEAR = 2'd3
   } ttlog_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FINISH,
      ST_SATURATE,
      ST_DIVIDE,
      ST_COMMIT,
      ST_APPLY,
      ST_DUMP_READ,
      ST_DUMP_EMIT,
      ST_RESPOND
   } ttlog_state_type;

   typedef struct packed {
      logic [SECS_W-1:0] secs;
      logic [CODE_W-1:0] code;
      logic [TYPE_W-1:0] kind;
   } ttlog_event_type;

   typedef struct packed {
      logic capture;
      logic evaluate;
      logic clear;
      logic div_init;
      logic div_step;
      logic commit;
      logic apply;
      logic dump_read;
      logic dump_emit;
      logic respond;
   } ttlog_cmd_type;

   typedef struct packed {
      ttlog_op_type op;
      logic         close_go;
      logic         saturated;
      logic         div_last;
      logic         dump_empty;
      logic         dump_last;
      logic         out_free;
   } ttlog_stat_type;

endpackage

// ===== design/timed_test_event_ring_log.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tuser cmd; tdata type, result, now_us, max_entries
// rsp_      out        rsp_tvalid/rsp_tready  tuser status, entry_valid; tdata event; tlast
// csr_      in         csr_valid/csr_ready    csr_index register, csr_data value
//
// Start and end pass finish, apply and respond if no running test is closed; clear skips apply.
// A close adds saturation check, 3-step divide and log write; saturation skips the divide.
// A dump: finish, any close, apply, RAM read, then one event per cycle while the output is free.
// A new command is accepted once the previous one has loaded its last beat into the output.
// Reset is synchronous; it empties the log, drops the running test and reloads the limits.
// A stalled output holds its beat, and the log RAM holds its read data until it moves on.
module timed_test_event_ring_log
   import ttlog_pkg::*;
#(
   parameter int LOG_DEPTH        = LOG_DEPTH_DEFAULT,
   parameter int TICKS_PER_SECOND = TICKS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] test_type, [15:8] result_code, [79:16] now_us, [84:80] max_entries
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] cmd
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] entry_type, [15:8] entry_result, [31:16] entry_time_s
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] status, [1] entry_valid
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data
);

   localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

   ttlog_cmd_type      cmd;
   ttlog_stat_type     stat;
   logic               ram_wr_en;
   logic [PTR_W-1:0]   ram_wr_addr;
   ttlog_event_type    ram_wr_data;
   logic               ram_rd_en;
   logic [PTR_W-1:0]   ram_rd_addr;
   logic [EVENT_W-1:0] ram_rd_data;

   assign csr_ready = 1'b1;

   ttlog_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ttlog_dp #(
      .LOG_DEPTH        (LOG_DEPTH),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .cmd         (cmd),
      .stat        (stat),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   ttlog_ram #(
      .WIDTH (EVENT_W),
      .DEPTH (LOG_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== design/ttlog_ram.sv =====
module ttlog_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ttlog_ctrl.sv =====
module ttlog_ctrl
   import ttlog_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  ttlog_stat_type stat,
   output ttlog_cmd_type  cmd
);

   ttlog_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.op == OP_CLEAR) begin
               state_in = ST_RESPOND;
            end else if (stat.close_go) begin
               state_in = ST_SATURATE;
            end else begin
               state_in = ST_APPLY;
            end
         end
         ST_SATURATE: begin
            state_in = stat.saturated ? ST_COMMIT : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (stat.div_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (stat.op == OP_DUMP && !stat.dump_empty) begin
               state_in = ST_DUMP_READ;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_DUMP_READ: begin
            state_in = ST_DUMP_EMIT;
         end
         ST_DUMP_EMIT: begin
            if (stat.out_free && stat.dump_last) state_in = ST_IDLE;
         end
         ST_RESPOND: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_FINISH: begin
            if (stat.op == OP_CLEAR) begin
               cmd.clear = 1'b1;
            end else begin
               cmd.evaluate = 1'b1;
            end
         end
         ST_SATURATE: begin
            cmd.div_init = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
         end
         ST_DUMP_READ: begin
            cmd.dump_read = 1'b1;
         end
         ST_DUMP_EMIT: begin
            // The RAM keeps its read data while the output is stalled, so the
            // next read goes out only together with an emitted beat.
            cmd.dump_emit = stat.out_free;
            cmd.dump_read = stat.out_free && !stat.dump_last;
         end
         ST_RESPOND: begin
            cmd.respond = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== design/ttlog_dp.sv =====
module ttlog_dp
   import ttlog_pkg::*;
#(
   parameter int LOG_DEPTH        = LOG_DEPTH_DEFAULT,
   parameter int TICKS_PER_SECOND = TICKS_DEFAULT,
   localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  ttlog_cmd_type         cmd,
   output ttlog_stat_type        stat,
   output logic                  ram_wr_en,
   output logic [PTR_W-1:0]      ram_wr_addr,
   output ttlog_event_type       ram_wr_data,
   output logic                  ram_rd_en,
   output logic [PTR_W-1:0]      ram_rd_addr,
   input  logic [EVENT_W-1:0]    ram_rd_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int CNT_W = $clog2(LOG_DEPTH + 1);
   localparam int CMP_W = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
   localparam logic [TIME_W-1:0] SAT_LIMIT = TIME_W'(TICKS_PER_SECOND) << SECS_W;
   localparam int RW = $clog2(SAT_LIMIT);
   localparam int RECIP_W = SECS_W + 1;
   localparam int PROD_W  = RW + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((TIME_W'(1) << RW) / TIME_W'(TICKS_PER_SECOND));
   localparam logic [RW-1:0]    TICKS_R  = RW'(TICKS_PER_SECOND);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LOG_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LOG_DEPTH);

   // Configuration and state that reset clears.
   logic [CFG_W-1:0]  type_limit_ff, type_limit_in;
   logic [CFG_W-1:0]  result_limit_ff, result_limit_in;
   logic [CFG_W-1:0]  error_code_ff, error_code_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TYPE_W-1:0] running_type_ff, running_type_in;
   logic [TIME_W-1:0] running_start_ff, running_start_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers of the item in progress.
   ttlog_op_type      op_ff, op_in;
   logic [TYPE_W-1:0] ttype_ff, ttype_in;
   logic [CODE_W-1:0] rcode_ff, rcode_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [MAXE_W-1:0] maxe_ff, maxe_in;
   logic              status_ff, status_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [RW-1:0]     prod_ff, prod_in;
   logic [SECS_W-1:0] quot_ff, quot_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [MAXE_W-1:0] remaining_ff, remaining_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CODE_W-1:0] close_code;
   logic [MAXE_W-1:0] dump_lim;
   logic [MAXE_W-1:0] dump_n;
   logic              out_free;
   logic [PROD_W-1:0] est_prod;
   logic [RW-1:0]     residue;

   assign close_code = (op_ff == OP_END) ? rcode_ff : error_code_ff;
   assign dump_lim   = (maxe_ff > DUMP_CAP) ? DUMP_CAP : maxe_ff;
   assign dump_n     = (CMP_W'(count_ff) < CMP_W'(dump_lim)) ? MAXE_W'(count_ff) : dump_lim;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // The reciprocal estimate of the seconds is exact or one low; the residue decides.
   assign est_prod = PROD_W'(rem_ff) * PROD_W'(RECIP);
   assign residue  = rem_ff - prod_ff;

   always_comb begin
      stat.op         = op_ff;
      stat.close_go   = (running_type_ff != '0) && (close_code <= result_limit_ff);
      stat.saturated  = elapsed_ff >= SAT_LIMIT;
      stat.div_last   = div_cnt_ff == DIV_FIX;
      stat.dump_empty = dump_n == '0;
      stat.dump_last  = remaining_ff == MAXE_W'(1);
      stat.out_free   = out_free;
   end

   always_comb begin
      type_limit_in    = type_limit_ff;
      result_limit_in  = result_limit_ff;
      error_code_in    = error_code_ff;
      wp_in            = wp_ff;
      count_in         = count_ff;
      running_type_in  = running_type_ff;
      running_start_in = running_start_ff;
      rsp_valid_in     = rsp_valid_ff;
      op_in            = op_ff;
      ttype_in         = ttype_ff;
      rcode_in         = rcode_ff;
      now_in           = now_ff;
      maxe_in          = maxe_ff;
      status_in        = status_ff;
      elapsed_in       = elapsed_ff;
      rem_in           = rem_ff;
      prod_in          = prod_ff;
      quot_in          = quot_ff;
      div_cnt_in       = div_cnt_ff;
      remaining_in     = remaining_ff;
      rd_ptr_in        = rd_ptr_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_user_in      = rsp_user_ff;
      rsp_last_in      = rsp_last_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = wp_ff;
      ram_wr_data      = '{secs: quot_ff, code: close_code, kind: running_type_ff};
      ram_rd_en        = cmd.dump_read;
      ram_rd_addr      = rd_ptr_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_TYPE_LIMIT:   type_limit_in   = csr_data;
            REG_RESULT_LIMIT: result_limit_in = csr_data;
            REG_ERROR_CODE:   error_code_in   = csr_data;
            default: ;
         endcase
      end

      if (cmd.capture) begin
         op_in    = ttlog_op_type'(req_tuser);
         ttype_in = req_tdata[7:0];
         rcode_in = req_tdata[15:8];
         now_in   = req_tdata[79:16];
         maxe_in  = req_tdata[84:80];
      end

      if (cmd.evaluate) begin
         status_in  = (running_type_ff != '0) && (close_code > result_limit_ff);
         elapsed_in = now_ff - running_start_ff;
      end

      if (cmd.clear) begin
         status_in        = 1'b0;
         wp_in            = '0;
         count_in         = '0;
         running_type_in  = '0;
         running_start_in = '0;
      end

      if (cmd.div_init) begin
         rem_in     = elapsed_ff[RW-1:0];
         div_cnt_in = DIV_EST;
         quot_in    = stat.saturated ? SECS_MAX : '0;
      end

      // Seconds in three steps: reciprocal estimate, back-multiply, one correction.
      if (cmd.div_step) begin
         case (div_cnt_ff)
            DIV_EST: quot_in = est_prod[RW +: SECS_W];
            DIV_MUL: prod_in = RW'(quot_ff) * TICKS_R;
            DIV_FIX: begin
               if (residue >= TICKS_R) quot_in = quot_ff + SECS_W'(1);
            end
            default: ;
         endcase
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
      end

      // A running type above a lowered limit is dropped without logging.
      if (cmd.commit) begin
         if (running_type_ff > type_limit_ff) begin
            status_in = 1'b1;
         end else begin
            status_in = 1'b0;
            ram_wr_en = 1'b1;
            wp_in     = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
            if (count_ff != CNT_FULL) count_in = count_ff + CNT_W'(1);
         end
         running_type_in  = '0;
         running_start_in = '0;
      end

      if (cmd.apply) begin
         case (op_ff)
            OP_START: begin
               if (ttype_ff > type_limit_ff) begin
                  status_in = 1'b1;
               end else begin
                  status_in        = 1'b0;
                  running_type_in  = ttype_ff;
                  running_start_in = now_ff;
               end
            end
            OP_DUMP: begin
               status_in    = 1'b0;
               remaining_in = dump_n;
               rd_ptr_in    = (wp_ff == '0) ? PTR_LAST : wp_ff - PTR_W'(1);
            end
            default: ;
         endcase
      end

      if (cmd.dump_read) begin
         rd_ptr_in = (rd_ptr_ff == '0) ? PTR_LAST : rd_ptr_ff - PTR_W'(1);
      end

      if (rsp_tready) rsp_valid_in = 1'b0;

      if (cmd.dump_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ram_rd_data;
         rsp_user_in  = 2'b10;
         rsp_last_in  = remaining_ff == MAXE_W'(1);
         remaining_in = remaining_ff - MAXE_W'(1);
      end

      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_user_in  = {1'b0, status_ff};
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_limit_ff    <= TYPE_LIMIT_RESET;
         result_limit_ff  <= RESULT_LIMIT_RESET;
         error_code_ff    <= ERROR_CODE_RESET;
         wp_ff            <= '0;
         count_ff         <= '0;
         running_type_ff  <= '0;
         running_start_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         type_limit_ff    <= type_limit_in;
         result_limit_ff  <= result_limit_in;
         error_code_ff    <= error_code_in;
         wp_ff            <= wp_in;
         count_ff         <= count_in;
         running_type_ff  <= running_type_in;
         running_start_ff <= running_start_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ttype_ff     <= ttype_in;
      rcode_ff     <= rcode_in;
      now_ff       <= now_in;
      maxe_ff      <= maxe_in;
      status_ff    <= status_in;
      elapsed_ff   <= elapsed_in;
      rem_ff       <= rem_in;
      prod_ff      <= prod_in;
      quot_ff      <= quot_in;
      div_cnt_ff   <= div_cnt_in;
      remaining_ff <= remaining_in;
      rd_ptr_ff    <= rd_ptr_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("event count exceeds log depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(cmd.dump_emit || cmd.respond))
      else $error("output beat overwritten while stalled");

   a_emit_has_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.dump_emit |-> (remaining_ff != '0))
      else $error("dump beat emitted with no entry left");

   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (running_type_ff == '0))
      else $error("running test not cleared after close");

endmodule
